// File: hw/rtl/gaussian_blur_clamped_grid_core_macros.svh
// Assertion macros for the clamped-grid blur core.
`ifndef GAUSSIAN_BLUR_CLAMPED_GRID_CORE_MACROS_SVH
`define GAUSSIAN_BLUR_CLAMPED_GRID_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define GBCG_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gbcg assertion failed");
// Next-cycle implication.
`define GBCG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gbcg assertion failed");
`else
`define GBCG_ASSERT_IMPLY(label, ante, cons)
`define GBCG_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: hw/rtl/gbcg_pkg.sv
// Shared types, constants and the blur tap table of the clamped-grid blur core.
package gbcg_pkg;

	localparam int CFG_BITS     = 9;
	localparam int NUM_TAPS     = 13;
	localparam int TAP_BITS     = 4;
	localparam int DRAIN_CYCLES = 2;
	localparam int WEIGHT_BITS  = 16;

	localparam logic [CFG_BITS-1:0] CFG_DIM_RESET = 9'd256;

	// Configuration register indexes.
	localparam logic CFG_COLS = 1'b0;
	localparam logic CFG_ROWS = 1'b1;

	// Item kinds.
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_READ  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	typedef struct packed {
		logic signed [2:0]       dx;
		logic signed [2:0]       dy;
		logic [WEIGHT_BITS-1:0]  w;
	} tap_t;

	typedef struct packed {
		logic                accept;
		logic                rd_en;
		logic [TAP_BITS-1:0] tap;
		logic                emit;
	} cmd_t;

	typedef struct packed {
		logic query_ok;
		logic out_busy;
	} status_t;

	// Thirteen taps within radius 2.2, Q0.16 weights that sum to exactly one.
	function automatic tap_t tap_entry(input logic [TAP_BITS-1:0] t);
		tap_t e;
		case (t)
			4'd0:    e = '{dx:  3'sd0, dy: -3'sd2, w: 16'd365};
			4'd1:    e = '{dx: -3'sd1, dy: -3'sd1, w: 16'd2811};
			4'd2:    e = '{dx:  3'sd0, dy: -3'sd1, w: 16'd7799};
			4'd3:    e = '{dx:  3'sd1, dy: -3'sd1, w: 16'd2811};
			4'd4:    e = '{dx: -3'sd2, dy:  3'sd0, w: 16'd365};
			4'd5:    e = '{dx: -3'sd1, dy:  3'sd0, w: 16'd7799};
			4'd6:    e = '{dx:  3'sd0, dy:  3'sd0, w: 16'd21636};
			4'd7:    e = '{dx:  3'sd1, dy:  3'sd0, w: 16'd7799};
			4'd8:    e = '{dx:  3'sd2, dy:  3'sd0, w: 16'd365};
			4'd9:    e = '{dx: -3'sd1, dy:  3'sd1, w: 16'd2811};
			4'd10:   e = '{dx:  3'sd0, dy:  3'sd1, w: 16'd7799};
			4'd11:   e = '{dx:  3'sd1, dy:  3'sd1, w: 16'd2811};
			4'd12:   e = '{dx:  3'sd0, dy:  3'sd2, w: 16'd365};
			default: e = '{dx:  3'sd0, dy:  3'sd0, w: 16'd0};
		endcase
		return e;
	endfunction

endpackage

// File: hw/rtl/gbcg_ctrl.sv
// Controller state machine: request intake, tap sequencing, pipeline drain and result hand-off.
module gbcg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  gbcg_pkg::status_t status,
	output gbcg_pkg::cmd_t    cmd
);

	gbcg_pkg::state_t              state_q;
	gbcg_pkg::state_t              state_d;
	logic [gbcg_pkg::TAP_BITS-1:0] cnt_q;
	logic [gbcg_pkg::TAP_BITS-1:0] cnt_d;

	assign in_stall   = (state_q != gbcg_pkg::ST_IDLE);
	assign cmd.accept = in_valid && (state_q == gbcg_pkg::ST_IDLE);
	assign cmd.rd_en  = (state_q == gbcg_pkg::ST_READ);
	assign cmd.tap    = cnt_q;
	assign cmd.emit   = (state_q == gbcg_pkg::ST_EMIT) && !status.out_busy;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			gbcg_pkg::ST_IDLE: begin
				cnt_d = '0;
				if (cmd.accept) begin
					// Writes and out-of-grid requests skip straight to the result.
					state_d = status.query_ok ? gbcg_pkg::ST_READ : gbcg_pkg::ST_EMIT;
				end
			end
			gbcg_pkg::ST_READ: begin
				if (cnt_q == gbcg_pkg::TAP_BITS'(gbcg_pkg::NUM_TAPS - 1)) begin
					cnt_d   = '0;
					state_d = gbcg_pkg::ST_DRAIN;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			gbcg_pkg::ST_DRAIN: begin
				if (cnt_q == gbcg_pkg::TAP_BITS'(gbcg_pkg::DRAIN_CYCLES - 1)) begin
					cnt_d   = '0;
					state_d = gbcg_pkg::ST_EMIT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			gbcg_pkg::ST_EMIT: begin
				if (!status.out_busy) begin
					state_d = gbcg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gbcg_pkg::ST_IDLE;
				cnt_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbcg_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// File: hw/rtl/gbcg_dp.sv
// Datapath: grid sizes, sample store, clamped tap addressing, multiply-accumulate and output register.
module gbcg_dp #(
	parameter int MAX_COLS    = 256,
	parameter int MAX_ROWS    = 256,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [gbcg_pkg::CFG_BITS-1:0]       cfg_data,
	input  logic                                kind,
	input  logic [7:0]                          x_coord,
	input  logic [7:0]                          y_coord,
	input  logic signed [SAMPLE_BITS-1:0]       height_in,
	input  gbcg_pkg::cmd_t                      cmd,
	output gbcg_pkg::status_t                   status,
	input  logic                                out_stall,
	output logic                                out_valid,
	output logic signed [SAMPLE_BITS-1:0]       blurred_height,
	output logic                                error
);

	localparam int DEPTH  = MAX_COLS * MAX_ROWS;
	localparam int AW     = $clog2(DEPTH);
	localparam int XW     = $clog2(MAX_COLS);
	localparam int YW     = $clog2(MAX_ROWS);
	localparam int CW     = $clog2(MAX_COLS + 1);
	localparam int RW     = $clog2(MAX_ROWS + 1);
	localparam int CXW    = ((XW > 8) ? XW : 8) + 2;
	localparam int CYW    = ((YW > 8) ? YW : 8) + 2;
	localparam int ACC_W  = SAMPLE_BITS + 17;
	localparam int Q_W    = ACC_W - 16;

	logic [gbcg_pkg::CFG_BITS-1:0] cols_q;
	logic [gbcg_pkg::CFG_BITS-1:0] rows_q;
	logic [CW-1:0]                 nc;
	logic [RW-1:0]                 nr;
	logic                          in_ok;

	logic [7:0] x_q;
	logic [7:0] y_q;
	logic       query_q;
	logic       err_q;

	gbcg_pkg::tap_t        tap;
	logic signed [CXW-1:0] sx;
	logic signed [CYW-1:0] sy;
	logic signed [CXW-1:0] lim_x;
	logic signed [CYW-1:0] lim_y;
	logic [XW-1:0]         cx;
	logic [YW-1:0]         cy;
	logic [AW-1:0]         rd_addr;
	logic [AW-1:0]         wr_addr;
	logic [AW-1:0]         mem_addr;
	logic                  mem_we;

	logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
	logic signed [SAMPLE_BITS-1:0] rd_s1;
	logic [gbcg_pkg::WEIGHT_BITS-1:0] w_s1;
	logic                          v_s1;
	logic signed [ACC_W-1:0]       prod_c;
	logic signed [ACC_W-1:0]       prod_s2;
	logic                          v_s2;
	logic signed [ACC_W-1:0]       acc_q;

	logic signed [ACC_W-1:0]       rnd;
	logic signed [Q_W-1:0]         q;
	logic signed [SAMPLE_BITS-1:0] sat;

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] blurred_q;
	logic                          error_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= gbcg_pkg::CFG_DIM_RESET;
			rows_q <= gbcg_pkg::CFG_DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				gbcg_pkg::CFG_COLS: cols_q <= cfg_data;
				gbcg_pkg::CFG_ROWS: rows_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A size of zero acts as one; sizes above the maximum saturate.
	always_comb begin
		if (cols_q == '0) begin
			nc = CW'(1);
		end else if (32'(cols_q) > MAX_COLS) begin
			nc = CW'(MAX_COLS);
		end else begin
			nc = CW'(cols_q);
		end
		if (rows_q == '0) begin
			nr = RW'(1);
		end else if (32'(rows_q) > MAX_ROWS) begin
			nr = RW'(MAX_ROWS);
		end else begin
			nr = RW'(rows_q);
		end
	end

	assign in_ok           = (32'(x_coord) < 32'(nc)) && (32'(y_coord) < 32'(nr));
	assign status.query_ok = in_ok && (kind == gbcg_pkg::KIND_QUERY);
	assign status.out_busy = out_valid_q && out_stall;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_q     <= x_coord;
			y_q     <= y_coord;
			query_q <= (kind == gbcg_pkg::KIND_QUERY);
			err_q   <= !in_ok;
		end
	end

	// Neighbor coordinates clamp to the nearest edge of the grid in use.
	always_comb begin
		tap   = gbcg_pkg::tap_entry(cmd.tap);
		sx    = $signed({{(CXW-8){1'b0}}, x_q}) + CXW'(tap.dx);
		sy    = $signed({{(CYW-8){1'b0}}, y_q}) + CYW'(tap.dy);
		lim_x = $signed(CXW'(nc - 1'b1));
		lim_y = $signed(CYW'(nr - 1'b1));
		if (sx < 0) begin
			cx = '0;
		end else if (sx > lim_x) begin
			cx = lim_x[XW-1:0];
		end else begin
			cx = sx[XW-1:0];
		end
		if (sy < 0) begin
			cy = '0;
		end else if (sy > lim_y) begin
			cy = lim_y[YW-1:0];
		end else begin
			cy = sy[YW-1:0];
		end
	end

	assign rd_addr  = AW'(32'(cy) * 32'(MAX_COLS) + 32'(cx));
	assign wr_addr  = AW'(32'(y_coord) * 32'(MAX_COLS) + 32'(x_coord));
	assign mem_we   = cmd.accept && (kind == gbcg_pkg::KIND_WRITE) && in_ok;
	assign mem_addr = mem_we ? wr_addr : rd_addr;

	// Single-port sample store with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= height_in;
		end
		rd_s1 <= mem[mem_addr];
		w_s1  <= tap.w;
	end

	assign prod_c = rd_s1 * $signed({1'b0, w_s1});

	always_ff @(posedge clk) begin
		prod_s2 <= prod_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + prod_s2;
		end
	end

	// Round half up by adding one half before dropping the 16 fraction bits.
	always_comb begin
		rnd = acc_q + ACC_W'(32'sd32768);
		q   = rnd[ACC_W-1:16];
		if (q > $signed({2'b00, {(SAMPLE_BITS-1){1'b1}}})) begin
			sat = $signed({1'b0, {(SAMPLE_BITS-1){1'b1}}});
		end else if (q < $signed({2'b11, {(SAMPLE_BITS-1){1'b0}}})) begin
			sat = $signed({1'b1, {(SAMPLE_BITS-1){1'b0}}});
		end else begin
			sat = q[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			blurred_q <= (query_q && !err_q) ? sat : '0;
			error_q   <= err_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign blurred_height = blurred_q;
	assign error          = error_q;

endmodule

// File: hw/rtl/gaussian_blur_clamped_grid_core.sv
// Top level of the clamped-grid blur core: controller, datapath and assertions.
//
// Usage: the request channel (in_valid / in_stall) carries one item per request:
// kind 0 stores height_in at (x_coord, y_coord), kind 1 asks for the 13-tap
// Gaussian blur at that cell with neighbors clamped to the grid edges. Every
// request gives exactly one result on the output channel (out_valid /
// out_stall): blurred_height and error. Error is set, and the value is zero,
// when the cell lies outside cols_used by rows_used.
// Sequence: an accepted query reads its taps one by one through the single
// memory port, drains the read and multiply registers, then rounds and loads
// its result. Writes and out-of-grid requests go from acceptance straight to
// the load. A load waits until the output register is free, and the intake
// reopens in the cycle after the load. One request is worked at a time.
// The result sits in an output register; a new request is taken while it
// waits, and a stalled receiver holds the finished result of the next one
// in the datapath, with the controller in its emit state, until the
// register is free. Reset sets both sizes to 256 and empties the pipeline;
// the sample store is not cleared, and each cell must be written before a
// query reaches it. cfg_we writes cfg_data into register cfg_index (0 columns,
// 1 rows); the user must do so only while idle; the block does not check it.
`include "gaussian_blur_clamped_grid_core_macros.svh"

module gaussian_blur_clamped_grid_core #(
	parameter int MAX_COLS    = 256,
	parameter int MAX_ROWS    = 256,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [gbcg_pkg::CFG_BITS-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          kind,
	input  logic [7:0]                    x_coord,
	input  logic [7:0]                    y_coord,
	input  logic signed [SAMPLE_BITS-1:0] height_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] blurred_height,
	output logic                          error
);

	gbcg_pkg::cmd_t    cmd;
	gbcg_pkg::status_t status;

	gbcg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	gbcg_dp #(
		.MAX_COLS    (MAX_COLS),
		.MAX_ROWS    (MAX_ROWS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.kind           (kind),
		.x_coord        (x_coord),
		.y_coord        (y_coord),
		.height_in      (height_in),
		.cmd            (cmd),
		.status         (status),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.blurred_height (blurred_height),
		.error          (error)
	);

	// An accepted request keeps the intake closed in the following cycle.
	`GBCG_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	// A result is never loaded over one that the receiver is still stalling.
	`GBCG_ASSERT_IMPLY(a_no_overwrite, cmd.emit, !(out_valid && out_stall))
	// An out-of-grid result always carries a zero value.
	`GBCG_ASSERT_IMPLY(a_error_zero, out_valid && error, blurred_height == '0)

endmodule
